FILE: design/rectangle_corner_containment_filter_core_defines.svh
// assertion macros used by the rectangle corner containment filter rtl
`ifndef RECTANGLE_CORNER_CONTAINMENT_FILTER_CORE_DEFINES_SVH
`define RECTANGLE_CORNER_CONTAINMENT_FILTER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define RCCF_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("rccf assertion failed");
`define RCCF_ASSERT_NEVER(lbl, cond) \
  `RCCF_ASSERT(lbl, !(cond))
`else
`define RCCF_ASSERT(lbl, prop)
`define RCCF_ASSERT_NEVER(lbl, cond)
`endif

`endif

FILE: design/rccf_pkg.sv
// package with constants, codes and control types of the containment filter
`timescale 1ns / 1ps
`default_nettype none

package rccf_pkg;

  localparam int unsigned POINT_SLOTS = 1024;
  localparam int unsigned ADDR_W      = $clog2(POINT_SLOTS);
  localparam int unsigned CNT_W       = $clog2(POINT_SLOTS + 1);
  localparam int unsigned COORD_W     = 16;
  localparam int unsigned ID_W        = 16;
  localparam int unsigned ACT_W       = 2;
  localparam int unsigned PT_W        = 2 * COORD_W;
  localparam int unsigned MAX_X       = 65535;
  localparam int unsigned MAX_Y       = 65535;

  typedef enum logic [ACT_W-1:0] {
    ACT_LOAD  = 2'd0,
    ACT_QUERY = 2'd1,
    ACT_CLEAR = 2'd2
  } action_e;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOAD = 4'b0010,
    S_SCAN = 4'b0100,
    S_EMIT = 4'b1000
  } state_e;

  typedef struct packed {
    logic capture;
    logic clear;
    logic load_step;
    logic scan_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic load_last;
    logic scan_done;
    logic out_busy;
  } stat_t;

  function automatic logic [COORD_W-1:0] clamp_x(input logic [COORD_W-1:0] x);
    logic [COORD_W-1:0] r;
    r = x;
    if (x == '0) begin
      r = COORD_W'(1);
    end else if (32'(x) > MAX_X) begin
      r = COORD_W'(MAX_X);
    end
    return r;
  endfunction

  // y span is nominal, values pass unchanged
  localparam logic [COORD_W-1:0] Y_SPAN = COORD_W'(MAX_Y);

endpackage

`default_nettype wire

FILE: design/rccf_if.sv
// handshake interfaces for the item and result channels
`timescale 1ns / 1ps
`default_nettype none

interface rccf_in_if import rccf_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ACT_W-1:0]   action;
  logic [COORD_W-1:0] min_x;
  logic [COORD_W-1:0] max_x;
  logic [COORD_W-1:0] min_y;
  logic [COORD_W-1:0] max_y;
  logic [ID_W-1:0]    rect_id;

  modport source (output valid, action, min_x, max_x, min_y, max_y, rect_id,
                  input ready);
  modport sink (input valid, action, min_x, max_x, min_y, max_y, rect_id,
                output ready);
endinterface

interface rccf_out_if import rccf_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [ID_W-1:0] result_id;
  logic            hit;
  logic            overflow;

  modport source (output valid, result_id, hit, overflow, input ready);
  modport sink (input valid, result_id, hit, overflow, output ready);
endinterface

`default_nettype wire

FILE: design/rccf_datapath.sv
// point store, scan compare and result register of the containment filter
`timescale 1ns / 1ps
`default_nettype none
`include "rectangle_corner_containment_filter_core_defines.svh"

module rccf_datapath import rccf_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire cmd_t               cmd_i,
  output      stat_t              stat_o,
  input  wire logic [ACT_W-1:0]   action_i,
  input  wire logic [COORD_W-1:0] min_x_i,
  input  wire logic [COORD_W-1:0] max_x_i,
  input  wire logic [COORD_W-1:0] min_y_i,
  input  wire logic [COORD_W-1:0] max_y_i,
  input  wire logic [ID_W-1:0]    rect_id_i,
  input  wire logic               out_ready_i,
  output      logic               out_valid_o,
  output      logic [ID_W-1:0]    result_id_o,
  output      logic               hit_o,
  output      logic               overflow_o
);

  logic [PT_W-1:0]    mem_q [POINT_SLOTS];
  logic [PT_W-1:0]    rd_data_q;
  logic [COORD_W-1:0] x1_q, x2_q, y1_q, y2_q;
  logic [ID_W-1:0]    id_q;
  logic [CNT_W-1:0]   count_q, scan_q;
  logic [1:0]         cnr_q;
  logic               rd_vld_q, hit_q, ovf_q, out_valid_q;
  logic [ID_W-1:0]    result_id_q;
  logic               res_hit_q, res_ovf_q;
  logic               full;
  logic               rd_en;
  logic               match;
  logic [COORD_W-1:0] cx, cy;
  logic [COORD_W-1:0] px, py;

  assign full  = count_q > CNT_W'(POINT_SLOTS - 4);
  assign rd_en = cmd_i.scan_step && (scan_q < count_q);

  // corner order: low-low, high-high, low-high, high-low
  always_comb begin
    case (cnr_q)
      2'd0:    begin cx = x1_q; cy = y1_q; end
      2'd1:    begin cx = x2_q; cy = y2_q; end
      2'd2:    begin cx = x1_q; cy = y2_q; end
      2'd3:    begin cx = x2_q; cy = y1_q; end
      default: begin cx = x1_q; cy = y1_q; end
    endcase
  end

  assign px    = rd_data_q[PT_W-1:COORD_W];
  assign py    = rd_data_q[COORD_W-1:0];
  assign match = (px >= x1_q) && (px <= x2_q) && (py >= y1_q) && (py <= y2_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_step) begin
      mem_q[count_q[ADDR_W-1:0]] <= {clamp_x(cx), cy & Y_SPAN | cy};
    end
    if (rd_en) begin
      rd_data_q <= mem_q[scan_q[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      x1_q <= min_x_i;
      x2_q <= max_x_i;
      y1_q <= min_y_i;
      y2_q <= max_y_i;
      id_q <= rect_id_i;
    end
    if (cmd_i.emit) begin
      result_id_q <= id_q;
      res_hit_q   <= hit_q;
      res_ovf_q   <= ovf_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      scan_q      <= '0;
      cnr_q       <= '0;
      rd_vld_q    <= 1'b0;
      hit_q       <= 1'b0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.capture) begin
        scan_q   <= '0;
        cnr_q    <= '0;
        rd_vld_q <= 1'b0;
        hit_q    <= 1'b0;
        ovf_q    <= (action_i == ACT_LOAD) && full;
      end else begin
        if (cmd_i.load_step) begin
          count_q <= count_q + CNT_W'(1);
          cnr_q   <= cnr_q + 2'd1;
        end
        if (cmd_i.scan_step) begin
          rd_vld_q <= rd_en;
          if (rd_en) begin
            scan_q <= scan_q + CNT_W'(1);
          end
          if (rd_vld_q && match) begin
            hit_q <= 1'b1;
          end
        end
      end
      if (cmd_i.clear) begin
        count_q <= '0;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign stat_o.full      = full;
  assign stat_o.load_last = (cnr_q == 2'd3);
  assign stat_o.scan_done = hit_q || (!rd_vld_q && (scan_q >= count_q));
  assign stat_o.out_busy  = out_valid_q && !out_ready_i;

  assign out_valid_o = out_valid_q;
  assign result_id_o = result_id_q;
  assign hit_o       = res_hit_q;
  assign overflow_o  = res_ovf_q;

  `RCCF_ASSERT(count_in_range_a, count_q <= CNT_W'(POINT_SLOTS))
  `RCCF_ASSERT(write_in_range_a, cmd_i.load_step |-> count_q < CNT_W'(POINT_SLOTS))
  `RCCF_ASSERT_NEVER(result_overwrite_a, cmd_i.emit && out_valid_q && !out_ready_i)
  `RCCF_ASSERT(scan_below_count_a, rd_en |=> rd_vld_q)

endmodule

`default_nettype wire

FILE: design/rccf_ctrl.sv
// controller state machine sequencing load, scan and result hand-off
`timescale 1ns / 1ps
`default_nettype none

module rccf_ctrl import rccf_pkg::*; (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic [ACT_W-1:0] action_i,
  output      logic             in_ready_o,
  input  wire stat_t            stat_i,
  output      cmd_t             cmd_o
);

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          if (action_i == ACT_LOAD && !stat_i.full) begin
            state_d = S_LOAD;
          end else if (action_i == ACT_QUERY) begin
            state_d = S_SCAN;
          end else begin
            cmd_o.clear = (action_i == ACT_CLEAR);
            state_d     = S_EMIT;
          end
        end
      end
      S_LOAD: begin
        cmd_o.load_step = 1'b1;
        if (stat_i.load_last) begin
          state_d = S_EMIT;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (stat_i.scan_done) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        // wait until the previous word has left the output register
        if (!stat_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/rectangle_corner_containment_filter_core.sv
// top level of the rectangle corner containment filter
//
//   port    dir  modport  word
//   req_i   in   sink     action, min_x, max_x, min_y, max_y, rect_id
//   res_o   out  source   result_id, hit, overflow
//
// one word at a time: a load writes its four corners to the store; clear, dropped load and
// other codes go straight to the hand-off; a query reads the stored corners, one store read
// per cycle, and ends early on the first hit.
// the next word is taken while the last result waits in the output register.
// reset empties the store at once; unwritten entries are never read.
// a stalled result holds the controller in its hand-off state.
`timescale 1ns / 1ps
`default_nettype none

module rectangle_corner_containment_filter_core import rccf_pkg::*; (
  input wire logic   clk_i,
  input wire logic   rst_ni,
  rccf_in_if.sink    req_i,
  rccf_out_if.source res_o
);

  cmd_t  cmd;
  stat_t stat;

  rccf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .action_i   (req_i.action),
    .in_ready_o (req_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rccf_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .action_i    (req_i.action),
    .min_x_i     (req_i.min_x),
    .max_x_i     (req_i.max_x),
    .min_y_i     (req_i.min_y),
    .max_y_i     (req_i.max_y),
    .rect_id_i   (req_i.rect_id),
    .out_ready_i (res_o.ready),
    .out_valid_o (res_o.valid),
    .result_id_o (res_o.result_id),
    .hit_o       (res_o.hit),
    .overflow_o  (res_o.overflow)
  );

endmodule

`default_nettype wire
